[hdl/assert_macros.svh]
// assertion macros used by the checker file imh_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/imh_pkg.sv]
// types, codes and fixed widths for the indexed min-heap
// no dependencies
package imh_pkg;

  localparam int ID_W    = 8;
  localparam int VAL_W   = 32;
  localparam int ID_SPAN = 256;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_ERASE   = 2'd1,
    MODE_EXTRACT = 2'd2,
    MODE_PEEK    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_PRESENT = 3'd3,
    ST_ABSENT  = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [ID_W-1:0]         item_id;
    logic signed [VAL_W-1:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [ID_W-1:0]         taken_id;
    logic signed [VAL_W-1:0] taken_value;
    logic                    min_valid;
    logic [ID_W-1:0]         min_id;
    logic signed [VAL_W-1:0] min_value;
    logic [8:0]              entry_count;
  } out_word_t;

  typedef enum logic [2:0] {
    HA_ZERO, HA_LAST, HA_PARENT, HA_LEFT, HA_RIGHT
  } hsel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_ER0, S_ER1, S_ER2,
    S_EX0, S_EX1, S_EX2, S_EX3,
    S_UP0, S_UP1, S_UP2,
    S_DN0, S_DN1, S_DN2, S_DN3, S_DN4,
    S_PLACE, S_FIN0, S_FIN1, S_FIN2
  } ctrl_state_t;

  typedef struct packed {
    logic    ld_in;
    hsel_t   hsel;
    logic    ins_do;
    logic    cap_pos_slot;
    logic    cap_mv_id;
    logic    cap_mv_val;
    logic    cap_tid;
    logic    cap_tval;
    logic    pos_zero;
    logic    cnt_dec;
    logic    clr_held_in;
    logic    clr_held_tid;
    logic    set_status;
    status_t status;
    logic    cap_oth;
    logic    up_move;
    logic    cap_lid;
    logic    cap_lval;
    logic    cap_rid;
    logic    pick;
    logic    dn_move;
    logic    place;
    logic    ld_out;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  id_ok;
    logic  held;
    logic  full;
    logic  empty;
    logic  single;
    logic  pos_is_top;
    logic  left_in;
    logic  last_hit;
    logic  up_less;
    logic  dn_stop;
  } sts_t;

endpackage

[hdl/imh_dp.sv]
// datapath: heap, position and value memories, mover registers, output register
// depends on imh_pkg
module imh_dp #(
  parameter int IDS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  imh_pkg::in_word_t  in_word,
  input  imh_pkg::cmd_t      cmd,
  output imh_pkg::sts_t      sts,
  output imh_pkg::out_word_t out_word
);

  localparam int SLOT_W = $clog2(IDS);
  localparam int CNT_W  = $clog2(IDS + 1);
  localparam int AW     = CNT_W + 1;

  logic [imh_pkg::ID_W-1:0]         heap_mem [IDS];
  logic [SLOT_W-1:0]                slot_mem [imh_pkg::ID_SPAN];
  logic signed [imh_pkg::VAL_W-1:0] val_mem  [imh_pkg::ID_SPAN];

  logic [imh_pkg::ID_SPAN-1:0] held_r, held_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;

  imh_pkg::in_word_t                in_r;
  imh_pkg::out_word_t               out_r;
  logic [2:0]                       status_r;
  logic [SLOT_W-1:0]                pos_r;
  logic [imh_pkg::ID_W-1:0]         mv_id_r, tid_r, oth_id_r, c_id_r, r_id_r;
  logic signed [imh_pkg::VAL_W-1:0] mv_val_r, tval_r, c_val_r;
  logic                             use_r_r;
  logic [imh_pkg::ID_W-1:0]         heap_q_r;
  logic signed [imh_pkg::VAL_W-1:0] val_q_r;
  logic [SLOT_W-1:0]                slot_q_r;

  logic [AW-1:0]            pos_x, left_x, right_x, last_x, parent_x;
  logic                     right_in;
  logic [SLOT_W-1:0]        heap_addr;
  logic                     wr_en;
  logic [imh_pkg::ID_W-1:0] wr_id;

  assign pos_x    = AW'(pos_r);
  assign left_x   = (pos_x << 1) + AW'(1);
  assign right_x  = left_x + AW'(1);
  assign last_x   = AW'(cnt_r) - AW'(1);
  assign parent_x = (pos_x - AW'(1)) >> 1;
  assign right_in = right_x < AW'(cnt_r);

  always_comb begin
    case (cmd.hsel)
      imh_pkg::HA_ZERO:   heap_addr = '0;
      imh_pkg::HA_LAST:   heap_addr = last_x[SLOT_W-1:0];
      imh_pkg::HA_PARENT: heap_addr = parent_x[SLOT_W-1:0];
      imh_pkg::HA_LEFT:   heap_addr = left_x[SLOT_W-1:0];
      imh_pkg::HA_RIGHT:  heap_addr = right_x[SLOT_W-1:0];
      default:            heap_addr = '0;
    endcase
  end

  // hole-style sifting: the mover is written only once it settles
  always_comb begin
    wr_en = cmd.up_move | cmd.dn_move | cmd.place;
    if (cmd.up_move) begin
      wr_id = oth_id_r;
    end else if (cmd.dn_move) begin
      wr_id = c_id_r;
    end else begin
      wr_id = mv_id_r;
    end
  end

  always_ff @(posedge clk) begin
    heap_q_r <= heap_mem[heap_addr];
    val_q_r  <= val_mem[heap_q_r];
    slot_q_r <= slot_mem[in_r.item_id];
    if (wr_en) begin
      heap_mem[pos_r] <= wr_id;
      slot_mem[wr_id] <= pos_r;
    end
    if (cmd.ins_do) begin
      val_mem[in_r.item_id] <= in_r.item_value;
    end
  end

  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    if (cmd.ins_do) begin
      held_nxt[in_r.item_id] = 1'b1;
      cnt_nxt                = cnt_r + CNT_W'(1);
    end
    if (cmd.clr_held_in) begin
      held_nxt[in_r.item_id] = 1'b0;
    end
    if (cmd.clr_held_tid) begin
      held_nxt[tid_r] = 1'b0;
    end
    if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cnt_r  <= '0;
    end else begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      in_r   <= in_word;
      tid_r  <= '0;
      tval_r <= '0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.ins_do) begin
      mv_id_r  <= in_r.item_id;
      mv_val_r <= in_r.item_value;
      pos_r    <= SLOT_W'(cnt_r);
    end
    if (cmd.cap_pos_slot) begin
      pos_r <= slot_q_r;
    end
    if (cmd.cap_mv_id) begin
      mv_id_r <= heap_q_r;
    end
    if (cmd.cap_mv_val) begin
      mv_val_r <= val_q_r;
    end
    if (cmd.cap_tid) begin
      tid_r <= heap_q_r;
    end
    if (cmd.cap_tval) begin
      tval_r <= val_q_r;
    end
    if (cmd.pos_zero) begin
      pos_r <= '0;
    end
    if (cmd.cap_oth) begin
      oth_id_r <= heap_q_r;
    end
    if (cmd.up_move) begin
      pos_r <= parent_x[SLOT_W-1:0];
    end
    if (cmd.cap_lid) begin
      c_id_r <= heap_q_r;
    end
    if (cmd.cap_lval) begin
      c_val_r <= val_q_r;
    end
    if (cmd.cap_rid) begin
      r_id_r <= heap_q_r;
    end
    if (cmd.pick) begin
      // left child wins a tie
      if (right_in && (val_q_r < c_val_r)) begin
        c_id_r  <= r_id_r;
        c_val_r <= val_q_r;
        use_r_r <= 1'b1;
      end else begin
        use_r_r <= 1'b0;
      end
    end
    if (cmd.dn_move) begin
      pos_r <= use_r_r ? right_x[SLOT_W-1:0] : left_x[SLOT_W-1:0];
    end
    if (cmd.ld_out) begin
      out_r.status      <= status_r;
      out_r.taken_id    <= tid_r;
      out_r.taken_value <= tval_r;
      out_r.min_valid   <= (cnt_r != '0);
      out_r.min_id      <= (cnt_r != '0) ? heap_q_r : '0;
      out_r.min_value   <= (cnt_r != '0) ? val_q_r : '0;
      out_r.entry_count <= 9'(cnt_r);
    end
  end

  always_comb begin
    sts.mode       = imh_pkg::mode_t'(in_r.mode);
    sts.id_ok      = (32'(in_r.item_id) < IDS);
    sts.held       = held_r[in_r.item_id];
    sts.full       = (32'(cnt_r) >= IDS);
    sts.empty      = (cnt_r == '0);
    sts.single     = (cnt_r == CNT_W'(1));
    sts.pos_is_top = (pos_r == '0);
    sts.left_in    = left_x < AW'(cnt_r);
    sts.last_hit   = (pos_x == last_x);
    sts.up_less    = mv_val_r < val_q_r;
    sts.dn_stop    = mv_val_r <= c_val_r;
  end

  assign out_word = out_r;

endmodule

[hdl/imh_ctrl.sv]
// sequencer for insert, erase, extract and the sift loops
// depends on imh_pkg
module imh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  imh_pkg::sts_t sts,
  output imh_pkg::cmd_t cmd
);

  imh_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imh_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      imh_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = imh_pkg::S_DISPATCH;
        end
      end
      imh_pkg::S_DISPATCH: begin
        cmd.set_status = 1'b1;
        cmd.status     = imh_pkg::ST_OK;
        state_nxt      = imh_pkg::S_FIN0;
        case (sts.mode)
          imh_pkg::MODE_INSERT: begin
            if (sts.full || !sts.id_ok) begin
              cmd.status = imh_pkg::ST_FULL;
            end else if (sts.held) begin
              cmd.status = imh_pkg::ST_PRESENT;
            end else begin
              cmd.ins_do = 1'b1;
              state_nxt  = imh_pkg::S_UP0;
            end
          end
          imh_pkg::MODE_ERASE: begin
            if (!sts.id_ok || !sts.held) begin
              cmd.status = imh_pkg::ST_ABSENT;
            end else begin
              state_nxt = imh_pkg::S_ER0;
            end
          end
          imh_pkg::MODE_EXTRACT: begin
            if (sts.empty) begin
              cmd.status = imh_pkg::ST_EMPTY;
            end else begin
              state_nxt = imh_pkg::S_EX0;
            end
          end
          default: begin
            state_nxt = imh_pkg::S_FIN0;
          end
        endcase
      end
      imh_pkg::S_ER0: begin
        cmd.cap_pos_slot = 1'b1;
        cmd.hsel         = imh_pkg::HA_LAST;
        state_nxt        = imh_pkg::S_ER1;
      end
      imh_pkg::S_ER1: begin
        cmd.cap_mv_id = 1'b1;
        state_nxt     = imh_pkg::S_ER2;
      end
      imh_pkg::S_ER2: begin
        cmd.cap_mv_val  = 1'b1;
        cmd.cnt_dec     = 1'b1;
        cmd.clr_held_in = 1'b1;
        state_nxt       = sts.last_hit ? imh_pkg::S_FIN0 : imh_pkg::S_UP0;
      end
      imh_pkg::S_EX0: begin
        state_nxt = imh_pkg::S_EX1;
      end
      imh_pkg::S_EX1: begin
        cmd.cap_tid = 1'b1;
        cmd.hsel    = imh_pkg::HA_LAST;
        state_nxt   = imh_pkg::S_EX2;
      end
      imh_pkg::S_EX2: begin
        cmd.cap_tval  = 1'b1;
        cmd.cap_mv_id = 1'b1;
        state_nxt     = imh_pkg::S_EX3;
      end
      imh_pkg::S_EX3: begin
        cmd.cap_mv_val   = 1'b1;
        cmd.pos_zero     = 1'b1;
        cmd.cnt_dec      = 1'b1;
        cmd.clr_held_tid = 1'b1;
        state_nxt        = sts.single ? imh_pkg::S_FIN0 : imh_pkg::S_DN0;
      end
      imh_pkg::S_UP0: begin
        if (sts.pos_is_top) begin
          state_nxt = (sts.mode == imh_pkg::MODE_ERASE) ? imh_pkg::S_DN0 : imh_pkg::S_PLACE;
        end else begin
          cmd.hsel  = imh_pkg::HA_PARENT;
          state_nxt = imh_pkg::S_UP1;
        end
      end
      imh_pkg::S_UP1: begin
        cmd.cap_oth = 1'b1;
        state_nxt   = imh_pkg::S_UP2;
      end
      imh_pkg::S_UP2: begin
        if (sts.up_less) begin
          cmd.up_move = 1'b1;
          state_nxt   = imh_pkg::S_UP0;
        end else begin
          state_nxt = (sts.mode == imh_pkg::MODE_ERASE) ? imh_pkg::S_DN0 : imh_pkg::S_PLACE;
        end
      end
      imh_pkg::S_DN0: begin
        if (sts.left_in) begin
          cmd.hsel  = imh_pkg::HA_LEFT;
          state_nxt = imh_pkg::S_DN1;
        end else begin
          state_nxt = imh_pkg::S_PLACE;
        end
      end
      imh_pkg::S_DN1: begin
        cmd.cap_lid = 1'b1;
        cmd.hsel    = imh_pkg::HA_RIGHT;
        state_nxt   = imh_pkg::S_DN2;
      end
      imh_pkg::S_DN2: begin
        cmd.cap_lval = 1'b1;
        cmd.cap_rid  = 1'b1;
        state_nxt    = imh_pkg::S_DN3;
      end
      imh_pkg::S_DN3: begin
        cmd.pick  = 1'b1;
        state_nxt = imh_pkg::S_DN4;
      end
      imh_pkg::S_DN4: begin
        if (sts.dn_stop) begin
          state_nxt = imh_pkg::S_PLACE;
        end else begin
          cmd.dn_move = 1'b1;
          state_nxt   = imh_pkg::S_DN0;
        end
      end
      imh_pkg::S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = imh_pkg::S_FIN0;
      end
      imh_pkg::S_FIN0: begin
        state_nxt = imh_pkg::S_FIN1;
      end
      imh_pkg::S_FIN1: begin
        state_nxt = imh_pkg::S_FIN2;
      end
      imh_pkg::S_FIN2: begin
        // top id and value are settled; wait for room in the output word
        if (!out_valid_r || !out_stall) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = imh_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = imh_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != imh_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hdl/indexed_min_heap.sv]
// top level of the indexed binary min-heap
// depends on imh_pkg, imh_ctrl, imh_dp
//
//  channel | handshake           | word
//  in      | in_valid / in_stall   | in_word  (mode, item_id, item_value)
//  out     | out_valid / out_stall | out_word (status, taken, min, entry_count)
//
// one word at a time: a new word is accepted only back in idle; an insert takes longer for each level
// risen and an extract or erase for each level sunk, set by the single read port of each memory
// reset clears the held flags and the count; memories need no clearing pass
// a waiting result does not block the next input word until its own result is ready
module indexed_min_heap #(
  parameter int IDS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  imh_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output imh_pkg::out_word_t out_word
);

  imh_pkg::cmd_t cmd;
  imh_pkg::sts_t sts;

  imh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  imh_dp #(.IDS(IDS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

[hdl/imh_checker.sv]
// port-level checks for the indexed min-heap, bound to the top level
// depends on imh_pkg and assert_macros.svh
`include "assert_macros.svh"

module imh_checker #(
  parameter int IDS = 256
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input imh_pkg::out_word_t out_word
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result word dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_word), "stalled word changed")
  `ASSERT_IMPLY(a_min_flag, clk, rst_n, out_valid, out_word.min_valid == (out_word.entry_count != 9'd0), "min flag disagrees with count")
  `ASSERT_IMPLY(a_fail_clean, clk, rst_n, out_valid && (out_word.status != imh_pkg::ST_OK), (out_word.taken_id == '0) && (out_word.taken_value == '0), "failed operation reports a taken entry")
  `ASSERT_IMPLY(a_count_cap, clk, rst_n, out_valid, 32'(out_word.entry_count) <= IDS, "count above capacity")

endmodule

bind indexed_min_heap imh_checker #(.IDS(IDS)) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

[bench/tb.sv]
// self-checking bench for the indexed min-heap: directed table then random traffic
// depends on imh_pkg and indexed_min_heap
`timescale 1ns / 100ps

module tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  imh_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  imh_pkg::out_word_t out_word;

  indexed_min_heap #(.IDS(256)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow heap
  logic [7:0]         hp_slot [256];
  logic [8:0]         slot_of [256];
  logic               held [256];
  logic signed [31:0] val_of [256];
  int unsigned        n_held;

  imh_pkg::out_word_t want_q[$];
  int                 errors = 0;
  int                 mism = 0;
  bit                 hold_off = 1'b0;
  bit                 feeding_done = 1'b0;

  function automatic void swap_slots(int a, int b);
    logic [7:0] t;
    t = hp_slot[a];
    hp_slot[a] = hp_slot[b];
    hp_slot[b] = t;
    slot_of[hp_slot[a]] = 9'(a);
    slot_of[hp_slot[b]] = 9'(b);
  endfunction

  function automatic void sift_up(int s);
    int p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (!(val_of[hp_slot[s]] < val_of[hp_slot[p]])) break;
      swap_slots(s, p);
      s = p;
    end
  endfunction

  function automatic void sift_down(int s);
    int l, c;
    while (2 * s + 1 < n_held) begin
      l = 2 * s + 1;
      c = l;
      if (l + 1 < n_held && val_of[hp_slot[l+1]] < val_of[hp_slot[l]]) c = l + 1;
      if (val_of[hp_slot[s]] <= val_of[hp_slot[c]]) break;
      swap_slots(s, c);
      s = c;
    end
  endfunction

  function automatic imh_pkg::out_word_t heap_apply(imh_pkg::in_word_t w);
    imh_pkg::out_word_t r;
    int p, last;
    r = '0;
    r.status = imh_pkg::ST_OK;
    case (imh_pkg::mode_t'(w.mode))
      imh_pkg::MODE_INSERT: begin
        if (n_held >= 256) r.status = imh_pkg::ST_FULL;
        else if (held[w.item_id]) r.status = imh_pkg::ST_PRESENT;
        else begin
          val_of[w.item_id] = w.item_value;
          held[w.item_id] = 1'b1;
          hp_slot[n_held] = w.item_id;
          slot_of[w.item_id] = 9'(n_held);
          n_held++;
          sift_up(n_held - 1);
        end
      end
      imh_pkg::MODE_ERASE: begin
        if (!held[w.item_id]) r.status = imh_pkg::ST_ABSENT;
        else begin
          p = slot_of[w.item_id];
          last = n_held - 1;
          held[w.item_id] = 1'b0;
          n_held = last;
          if (p != last) begin
            hp_slot[p] = hp_slot[last];
            slot_of[hp_slot[p]] = 9'(p);
            sift_up(p);
            sift_down(slot_of[hp_slot[p]]);
          end
        end
      end
      imh_pkg::MODE_EXTRACT: begin
        if (n_held == 0) r.status = imh_pkg::ST_EMPTY;
        else begin
          r.taken_id = hp_slot[0];
          r.taken_value = val_of[hp_slot[0]];
          swap_slots(0, n_held - 1);
          n_held--;
          held[r.taken_id] = 1'b0;
          sift_down(0);
        end
      end
      default: ;
    endcase
    if (n_held > 0) begin
      r.min_valid = 1'b1;
      r.min_id = hp_slot[0];
      r.min_value = val_of[hp_slot[0]];
    end
    r.entry_count = n_held[8:0];
    return r;
  endfunction

  // directed rows; typed result used where has_want is set
  typedef struct {
    imh_pkg::mode_t     m;
    logic [7:0]         id;
    logic signed [31:0] v;
    bit                 has_want;
    imh_pkg::out_word_t want;
  } row_t;

  function automatic imh_pkg::out_word_t ow(imh_pkg::status_t s, logic [8:0] cnt);
    imh_pkg::out_word_t r;
    r = '0;
    r.status = s;
    r.entry_count = cnt;
    return r;
  endfunction

  // entered and left at a falling edge; valid stays high into the next word
  // unless a gap drops it
  task automatic send_word(imh_pkg::in_word_t w, imh_pkg::out_word_t typed, bit use_typed);
    imh_pkg::out_word_t p;
    int g;
    if ($urandom_range(0, 3) == 0) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    p = heap_apply(w);
    want_q.push_back(use_typed ? typed : p);
    @(negedge clk);
  endtask

  task automatic send_op(imh_pkg::mode_t m, logic [7:0] id, logic signed [31:0] v);
    imh_pkg::in_word_t w;
    w.mode = m;
    w.item_id = id;
    w.item_value = v;
    send_word(w, '0, 1'b0);
  endtask

  // output checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        errors++;
        if (mism < 10) $display("unexpected result word %h", out_word);
        mism++;
      end else begin
        imh_pkg::out_word_t e;
        e = want_q.pop_front();
        if (out_word !== e) begin
          errors++;
          if (mism < 10)
            $display("mismatch: expected st=%0d tk=%0d/%0d mv=%0b min=%0d/%0d n=%0d, got st=%0d tk=%0d/%0d mv=%0b min=%0d/%0d n=%0d",
                     e.status, e.taken_id, e.taken_value, e.min_valid, e.min_id, e.min_value,
                     e.entry_count, out_word.status, out_word.taken_id, out_word.taken_value,
                     out_word.min_valid, out_word.min_id, out_word.min_value,
                     out_word.entry_count);
          mism++;
        end
      end
    end
  end

  // receiver stalls, with one long hold-off on request
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!feeding_done && $urandom_range(0, 5) == 0) begin
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (g) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t r;
    imh_pkg::out_word_t t;
    int k, sel, w;
    logic [7:0] pick;
    for (k = 0; k < 256; k++) held[k] = 1'b0;
    n_held = 0;

    // after reset: empty and absent cases, then extremes
    r.m = imh_pkg::MODE_PEEK; r.id = 8'hff; r.v = 0; r.has_want = 1;
    r.want = ow(imh_pkg::ST_OK, 9'd0);
    rows.push_back(r);
    r.m = imh_pkg::MODE_EXTRACT; r.id = 8'd0; r.v = 0; r.has_want = 1;
    r.want = ow(imh_pkg::ST_EMPTY, 9'd0);
    rows.push_back(r);
    r.m = imh_pkg::MODE_ERASE; r.id = 8'd7; r.v = 0; r.has_want = 1;
    r.want = ow(imh_pkg::ST_ABSENT, 9'd0);
    rows.push_back(r);
    t = ow(imh_pkg::ST_OK, 9'd1); t.min_valid = 1; t.min_id = 8'hff; t.min_value = 32'h7fffffff;
    r.m = imh_pkg::MODE_INSERT; r.id = 8'hff; r.v = 32'h7fffffff; r.has_want = 1; r.want = t;
    rows.push_back(r);
    t = ow(imh_pkg::ST_PRESENT, 9'd1); t.min_valid = 1; t.min_id = 8'hff;
    t.min_value = 32'h7fffffff;
    r.m = imh_pkg::MODE_INSERT; r.id = 8'hff; r.v = 32'sh80000000; r.has_want = 1; r.want = t;
    rows.push_back(r);
    r.has_want = 0;
    r.m = imh_pkg::MODE_INSERT;  r.id = 8'h00; r.v = 32'sh80000000; rows.push_back(r);
    r.m = imh_pkg::MODE_INSERT;  r.id = 8'h55; r.v = 5;  rows.push_back(r);
    r.m = imh_pkg::MODE_INSERT;  r.id = 8'haa; r.v = 5;  rows.push_back(r);
    r.m = imh_pkg::MODE_INSERT;  r.id = 8'h10; r.v = -1; rows.push_back(r);
    r.m = imh_pkg::MODE_INSERT;  r.id = 8'h20; r.v = 0;  rows.push_back(r);
    r.m = imh_pkg::MODE_PEEK;    r.id = 8'h3c; r.v = -7; rows.push_back(r);
    r.m = imh_pkg::MODE_ERASE;   r.id = 8'h55; r.v = 0;  rows.push_back(r);
    r.m = imh_pkg::MODE_ERASE;   r.id = 8'h00; r.v = 0;  rows.push_back(r);
    r.m = imh_pkg::MODE_ERASE;   r.id = 8'h20; r.v = 0;  rows.push_back(r);
    r.m = imh_pkg::MODE_EXTRACT; r.id = 8'h99; r.v = 9;  rows.push_back(r);
    r.m = imh_pkg::MODE_EXTRACT; r.id = 8'h00; r.v = 0;  rows.push_back(r);
    r.m = imh_pkg::MODE_EXTRACT; r.id = 8'h00; r.v = 0;  rows.push_back(r);
    r.m = imh_pkg::MODE_EXTRACT; r.id = 8'h00; r.v = 0;  rows.push_back(r);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      imh_pkg::in_word_t iw;
      iw.mode = rows[i].m;
      iw.item_id = rows[i].id;
      iw.item_value = rows[i].v;
      send_word(iw, rows[i].want, rows[i].has_want);
    end

    // fill to capacity, the receiver holding off at first, then inserts refused as full
    hold_off = 1'b1;
    for (k = 0; k < 256; k++) send_op(imh_pkg::MODE_INSERT, k[7:0], $urandom);
    send_op(imh_pkg::MODE_INSERT, 8'h80, 32'sh80000000);
    send_op(imh_pkg::MODE_INSERT, 8'h01, -1);
    for (k = 0; k < 40; k++) send_op(imh_pkg::MODE_ERASE, 8'($urandom_range(0, 255)), 0);
    for (k = 0; k < 100; k++) send_op(imh_pkg::MODE_EXTRACT, 8'd0, 0);

    // random mix; small value range sometimes to force ties
    for (k = 0; k < 200; k++) begin
      sel = $urandom_range(0, 99);
      w = $urandom_range(0, 2);
      if (w == 0) pick = 8'($urandom);
      else pick = 8'($urandom_range(0, 31));
      if (sel < 45)
        send_op(imh_pkg::MODE_INSERT, pick,
                (w == 1) ? $signed($urandom_range(0, 6)) - 3 : $urandom);
      else if (sel < 65) send_op(imh_pkg::MODE_ERASE, pick, $urandom);
      else if (sel < 92) send_op(imh_pkg::MODE_EXTRACT, 8'($urandom), $urandom);
      else send_op(imh_pkg::MODE_PEEK, 8'($urandom), $urandom);
    end
    while (n_held > 0) send_op(imh_pkg::MODE_EXTRACT, 8'd0, 0);
    send_op(imh_pkg::MODE_EXTRACT, 8'd0, 0);
    in_valid <= 1'b0;

    feeding_done = 1'b1;
    wait (want_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
